[hdl/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, saturation and arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // configuration register indexes
  localparam logic [2:0] RegWheelRadius   = 3'd0;
  localparam logic [2:0] RegRadiusOverBase = 3'd1;
  localparam logic [2:0] RegStartHeading  = 3'd2;
  localparam logic [2:0] RegStartX        = 3'd3;
  localparam logic [2:0] RegStartY        = 3'd4;

  // 4*pi in rad * 2^24
  localparam logic [27:0] FourPiQ24 = 28'd210828714;
  localparam logic signed [28:0] FourPiQ24S = 29'sd210828714;

  // angles in Q30 radians
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [32:0] GainQ30   = 33'sd652032874;

  localparam logic signed [45:0] Max40 = 46'sd549755813887;
  localparam logic signed [45:0] Min40 = -46'sd549755813888;

  function automatic logic signed [39:0] sat40(logic signed [45:0] v);
    logic signed [39:0] r;
    if (v > Max40) begin
      r = Max40[39:0];
    end else if (v < Min40) begin
      r = Min40[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  // arctangent of 2^-i in Q30, truncated
  function automatic logic [29:0] atan_q30(logic [4:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:    a = 30'd843314856;
      5'd1:    a = 30'd497837829;
      5'd2:    a = 30'd263043836;
      5'd3:    a = 30'd133525158;
      5'd4:    a = 30'd67021686;
      5'd5:    a = 30'd33543515;
      5'd6:    a = 30'd16775850;
      5'd7:    a = 30'd8388437;
      5'd8:    a = 30'd4194282;
      5'd9:    a = 30'd2097149;
      5'd10:   a = 30'd1048575;
      5'd11:   a = 30'd524287;
      5'd12:   a = 30'd262143;
      5'd13:   a = 30'd131071;
      5'd14:   a = 30'd65535;
      5'd15:   a = 30'd32767;
      5'd16:   a = 30'd16383;
      5'd17:   a = 30'd8191;
      5'd18:   a = 30'd4095;
      5'd19:   a = 30'd2047;
      5'd20:   a = 30'd1023;
      5'd21:   a = 30'd511;
      5'd22:   a = 30'd255;
      5'd23:   a = 30'd127;
      5'd24:   a = 30'd63;
      5'd25:   a = 30'd31;
      5'd26:   a = 30'd15;
      5'd27:   a = 30'd7;
      5'd28:   a = 30'd3;
      5'd29:   a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

[hdl/differential_drive_odometry_top.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning pose of a differential-drive base from cumulative wheel angles.
// ----------------------------------------------------------------------------
// One request at a time: a new wheel-angle pair is taken only once the previous
// one has left the arithmetic, and its pose goes to an output register that may
// wait for the consumer while the next pair is being worked on. Each item goes
// through two bit-serial multiplies, a 42-step restoring remainder for the
// heading modulo 4*pi, normalisation of the angle, CORDIC_STEPS rotations of
// the iterative CORDIC, and setup, rounding, accumulation and offsetting.
// Configuration writes are always taken and are meant for idle periods only.
module differential_drive_odometry_top
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [39:0] left_wheel_angle_i,
  input  logic signed [39:0] right_wheel_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [39:0] x_position_o,
  output logic signed [39:0] y_position_o,
  output logic signed [28:0] heading_o,
  output logic signed [39:0] travelled_path_o
);

  localparam int unsigned StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul1  = 4'd1;
  localparam logic [3:0] StHead  = 4'd2;
  localparam logic [3:0] StDiv   = 4'd3;
  localparam logic [3:0] StNorm  = 4'd4;
  localparam logic [3:0] StCord  = 4'd5;
  localparam logic [3:0] StRound = 4'd6;
  localparam logic [3:0] StMul2  = 4'd7;
  localparam logic [3:0] StAcc   = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0] state_q;

  // configuration
  logic [15:0]        wheel_radius_q, radius_over_base_q;
  logic signed [28:0] start_heading_q;
  logic signed [31:0] start_x_q, start_y_q;

  // state
  logic signed [39:0] prev_path_q, x_off_q, y_off_q;

  // datapath
  logic signed [39:0] path_q;
  logic signed [41:0] turn_q;
  logic [41:0]        dvd_q;
  logic               hneg_q;
  logic [27:0]        rem_q;
  logic [5:0]         div_cnt_q;
  logic signed [28:0] head_q;
  logic signed [35:0] z_q;
  logic signed [32:0] x_q, y_q;
  logic               flip_q;
  logic [StepW-1:0]   step_q;
  logic signed [44:0] x_inc_q, y_inc_q;

  // output register
  logic               out_valid_q;
  logic signed [39:0] x_pos_q, y_pos_q, path_out_q;
  logic signed [28:0] head_out_q;

  logic in_req, out_free;
  assign in_ready_o  = (state_q == StIdle);
  assign in_req      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // multipliers: path and turn first, then the cosine and sine products
  logic               mul_start, done0, done1, mul_done;
  logic signed [40:0] a0, a1;
  logic signed [23:0] b0, b1;
  logic signed [64:0] p0, p1;
  logic signed [40:0] delta;
  logic signed [32:0] x_f, y_f, x_r, y_r;
  logic signed [23:0] cos_r, sin_r;

  assign mul_start = in_req || (state_q == StRound);
  assign mul_done  = done0 && done1;
  assign delta     = {path_q[39], path_q} - {prev_path_q[39], prev_path_q};
  assign x_f       = flip_q ? -x_q : x_q;
  assign y_f       = flip_q ? -y_q : y_q;
  assign x_r       = x_f + 33'sd512;
  assign y_r       = y_f + 33'sd512;
  assign cos_r     = {x_r[32], x_r[32:10]};
  assign sin_r     = {y_r[32], y_r[32:10]};

  always_comb begin
    if (state_q == StRound) begin
      a0 = delta;
      b0 = cos_r;
      a1 = delta;
      b1 = sin_r;
    end else begin
      a0 = {left_wheel_angle_i[39], left_wheel_angle_i}
         + {right_wheel_angle_i[39], right_wheel_angle_i};
      b0 = {8'd0, wheel_radius_q};
      a1 = {right_wheel_angle_i[39], right_wheel_angle_i}
         - {left_wheel_angle_i[39], left_wheel_angle_i};
      b1 = {8'd0, radius_over_base_q};
    end
  end

  ddo_mul #(.AW(41), .BW(24)) u_mul0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a0),
    .b_i     (b0),
    .done_o  (done0),
    .p_o     (p0)
  );

  ddo_mul #(.AW(41), .BW(24)) u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a1),
    .b_i     (b1),
    .done_o  (done1),
    .p_o     (p1)
  );

  // rounding of the products, half toward plus infinity
  logic signed [64:0] p0_path, p1_turn, p0_inc, p1_inc;
  assign p0_path = p0 + 65'sd16777216;
  assign p1_turn = p1 + 65'sd32768;
  assign p0_inc  = p0 + 65'sd524288;
  assign p1_inc  = p1 + 65'sd524288;

  // heading before reduction
  logic signed [41:0] head_sum;
  assign head_sum = {{13{start_heading_q[28]}}, start_heading_q} + turn_q;

  // restoring remainder step
  logic [28:0] trial;
  logic [27:0] rem_d;
  logic signed [28:0] head_d;
  assign trial  = {rem_q, dvd_q[41]};
  assign rem_d  = (trial >= {1'b0, FourPiQ24}) ? 28'(trial - {1'b0, FourPiQ24})
                                                : trial[27:0];
  assign head_d = hneg_q ? -$signed({1'b0, rem_d}) : $signed({1'b0, rem_d});

  // cordic rotation step
  logic signed [32:0] x_sh, y_sh;
  logic signed [35:0] atan_v;
  logic               last_step;
  assign x_sh      = x_q >>> step_q;
  assign y_sh      = y_q >>> step_q;
  assign atan_v    = $signed({6'd0, atan_q30(5'(step_q))});
  assign last_step = (step_q == StepW'(CORDIC_STEPS - 1));

  // accumulation and pose
  logic signed [39:0] x_acc, y_acc, x_pose, y_pose;
  assign x_acc  = sat40({{6{x_off_q[39]}}, x_off_q} + {x_inc_q[44], x_inc_q});
  assign y_acc  = sat40({{6{y_off_q[39]}}, y_off_q} + {y_inc_q[44], y_inc_q});
  assign x_pose = sat40({{14{start_x_q[31]}}, start_x_q} + {{6{x_off_q[39]}}, x_off_q});
  assign y_pose = sat40({{14{start_y_q[31]}}, start_y_q} + {{6{y_off_q[39]}}, y_off_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= StIdle;
      out_valid_q        <= 1'b0;
      wheel_radius_q     <= '0;
      radius_over_base_q <= '0;
      start_heading_q    <= '0;
      start_x_q          <= '0;
      start_y_q          <= '0;
      prev_path_q        <= '0;
      x_off_q            <= '0;
      y_off_q            <= '0;
      div_cnt_q          <= '0;
      step_q             <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegWheelRadius:    wheel_radius_q     <= cfg_data_i[15:0];
          RegRadiusOverBase: radius_over_base_q <= cfg_data_i[15:0];
          RegStartHeading:   start_heading_q    <= cfg_data_i[28:0];
          RegStartX:         start_x_q          <= cfg_data_i;
          RegStartY:         start_y_q          <= cfg_data_i;
          default: ;
        endcase
      end

      if ((state_q == StOut) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_req) begin
            state_q <= StMul1;
          end
        end
        StMul1: begin
          if (mul_done) begin
            state_q <= StHead;
          end
        end
        StHead: begin
          div_cnt_q <= '0;
          state_q   <= StDiv;
        end
        StDiv: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 6'd41) begin
            state_q <= StNorm;
          end
        end
        StNorm: begin
          if (!(z_q > PiQ30) && !(z_q < -PiQ30)) begin
            step_q  <= '0;
            state_q <= StCord;
          end
        end
        StCord: begin
          step_q <= step_q + 1'b1;
          if (last_step) begin
            state_q <= StRound;
          end
        end
        StRound: begin
          state_q <= StMul2;
        end
        StMul2: begin
          if (mul_done) begin
            state_q <= StAcc;
          end
        end
        StAcc: begin
          x_off_q     <= x_acc;
          y_off_q     <= y_acc;
          prev_path_q <= path_q;
          state_q     <= StOut;
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StMul1: begin
        if (mul_done) begin
          // the path product never leaves 33 bits, so no clamp is needed
          path_q <= p0_path[64:25];
          turn_q <= p1_turn[57:16];
        end
      end
      StHead: begin
        hneg_q <= head_sum[41];
        dvd_q  <= head_sum[41] ? 42'(-head_sum) : 42'(head_sum);
        rem_q  <= '0;
      end
      StDiv: begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[40:0], 1'b0};
        if (div_cnt_q == 6'd41) begin
          head_q <= head_d;
          z_q    <= {{1{head_d[28]}}, head_d, 6'd0};
        end
      end
      StNorm: begin
        if (z_q > PiQ30) begin
          z_q <= z_q - TwoPiQ30;
        end else if (z_q < -PiQ30) begin
          z_q <= z_q + TwoPiQ30;
        end else begin
          // fold into the right half plane, sign of the result flips
          if (z_q > HalfPiQ30) begin
            z_q    <= z_q - PiQ30;
            flip_q <= 1'b1;
          end else if (z_q < -HalfPiQ30) begin
            z_q    <= z_q + PiQ30;
            flip_q <= 1'b1;
          end else begin
            flip_q <= 1'b0;
          end
          x_q <= GainQ30;
          y_q <= '0;
        end
      end
      StCord: begin
        if (!z_q[35]) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + atan_v;
        end
      end
      StMul2: begin
        if (mul_done) begin
          x_inc_q <= p0_inc[64:20];
          y_inc_q <= p1_inc[64:20];
        end
      end
      StOut: begin
        if (out_free) begin
          x_pos_q    <= x_pose;
          y_pos_q    <= y_pose;
          head_out_q <= head_q;
          path_out_q <= path_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign x_position_o     = x_pos_q;
  assign y_position_o     = y_pos_q;
  assign heading_o        = head_out_q;
  assign travelled_path_o = path_out_q;

endmodule

[hdl/ddo_mul.sv]
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial signed multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module ddo_mul #(
  parameter int unsigned AW = 41,
  parameter int unsigned BW = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [AW-1:0]       a_i,
  input  logic signed [BW-1:0]       b_i,
  output logic                       done_o,
  output logic signed [AW+BW-1:0]    p_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = (BW > 1) ? $clog2(BW) : 1;

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic signed [PW-1:0] a_q, acc_q, pp;
  logic [BW-1:0]     b_q;
  logic              last;

  assign last = (cnt_q == CW'(BW - 1));

  always_comb begin
    pp = b_q[0] ? a_q : '0;
    // the top bit of a two's complement multiplier weighs negative
    if (last) begin
      pp = -pp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{BW{a_i[AW-1]}}, a_i};
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
      acc_q <= acc_q + pp;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

[hdl/ddo_checker.sv]
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks on the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker
  import ddo_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [39:0] x_position_o,
  input logic signed [39:0] y_position_o,
  input logic signed [28:0] heading_o,
  input logic signed [39:0] travelled_path_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(x_position_o) && $stable(y_position_o)
      && $stable(heading_o) && $stable(travelled_path_o))
    else $error("result changed while stalled");

  // one request in flight: never ready right after taking one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // reduced heading stays strictly inside 4*pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o < FourPiQ24S) && (heading_o > -FourPiQ24S))
    else $error("heading out of range");

endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (.*);
